// ===== hdl/rcns_pkg.sv =====
// Shared types, widths and helpers for the row carve node selector.
// Used by every module under hdl; depends on nothing.
package rcns_pkg;

    localparam int MAX_ROW_WIDTH = 4096;
    localparam int CNT_W         = $clog2(MAX_ROW_WIDTH + 1);
    localparam int POS_W         = 12;
    localparam int HUE_W         = 15;
    localparam int LUM_W         = 16;

    // One full turn of hue in 1/64 degree
    localparam logic [HUE_W-1:0] FULL_TURN = 15'd23040;

    typedef enum logic [1:0] {
        ROW_OK       = 2'd0,
        ROW_SHORT    = 2'd1,
        ROW_OVERFLOW = 2'd2
    } row_status_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [LUM_W-1:0] luminance;
        logic             last;
    } pixel_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        row_status_t      status;
    } result_t;

    // Circular hue distance: min(|a-b|, |FULL_TURN-|a-b||)
    function automatic logic [HUE_W-1:0] circ_diff(input logic [HUE_W-1:0] a,
                                                   input logic [HUE_W-1:0] b);
        logic [HUE_W-1:0] d;
        logic [HUE_W-1:0] e;
        d = (a > b) ? (a - b) : (b - a);
        e = (d > FULL_TURN) ? (d - FULL_TURN) : (FULL_TURN - d);
        return (d < e) ? d : e;
    endfunction

endpackage

// ===== hdl/row_carve_node_select_top.sv =====
// The result of a row is registered in the input register, which captures on the beat of its last
// pixel, and then in the result register, which captures when the row stage takes that pixel.
// Throughput: one pixel per cycle unless a last pixel stalls; the row state is registered per taken pixel.
// A last pixel stalls only while the previous result is still held in the output.
// Reset clears the row state and sets selection_mode to 0 (minimum luminance).
// Depends on rcns_pkg, rcns_in_stage, rcns_row_eval, rcns_out_stage.
module row_carve_node_select_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       selection_mode,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rcns_pkg::HUE_W-1:0] hue,
    input  logic [rcns_pkg::LUM_W-1:0] luminance,
    input  logic                       last_in_row,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rcns_pkg::POS_W-1:0] selected_position,
    output logic [1:0]                 row_status
);
    import rcns_pkg::*;

    logic    mode_reg;
    pixel_t  in_pix;
    pixel_t  s1_pix;
    logic    s1_valid;
    logic    s1_take;
    logic    out_free;
    logic    res_valid;
    result_t res;
    result_t out_res;

    // mode register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= selection_mode;
        end
    end

    assign in_pix = '{hue: hue, luminance: luminance, last: last_in_row};

    rcns_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_pix   (in_pix),
        .s1_valid (s1_valid),
        .s1_pix   (s1_pix),
        .s1_take  (s1_take)
    );

    rcns_row_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .s1_valid  (s1_valid),
        .s1_pix    (s1_pix),
        .s1_take   (s1_take),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    rcns_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign selected_position = out_res.position;
    assign row_status        = out_res.status;

    // flagged rows never name a pixel
    a_flag_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (row_status != ROW_OK) |-> selected_position == '0)
        else $error("flagged row carries a nonzero position");

    // a held result beat keeps its payload until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(selected_position)
            && $stable(row_status))
        else $error("held result changed before it was taken");

    // input only backs up behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a pending result");

endmodule

// ===== hdl/rcns_in_stage.sv =====
// Input register stage: captures one pixel beat per cycle while it is empty or its pixel moves on.
// Depends on rcns_pkg.
module rcns_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rcns_pkg::pixel_t in_pix,
    output logic            s1_valid,
    output rcns_pkg::pixel_t s1_pix,
    input  logic            s1_take
);
    import rcns_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    pixel_t pix_reg;

    // free when empty or the held pixel moves on this cycle
    assign in_ready = !valid_reg || s1_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (s1_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pix_reg <= in_pix;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_pix   = pix_reg;

endmodule

// ===== hdl/rcns_row_eval.sv =====
// Row state and candidate selection: hue window, running minimum, pixel count.
// Depends on rcns_pkg.
module rcns_row_eval (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mode,
    input  logic             s1_valid,
    input  rcns_pkg::pixel_t s1_pix,
    output logic             s1_take,
    input  logic             out_free,
    output logic             res_valid,
    output rcns_pkg::result_t res
);
    import rcns_pkg::*;

    logic [HUE_W-1:0] prev_hue_reg,   prev_hue_next;
    logic [HUE_W-1:0] prev_diff_reg,  prev_diff_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic [POS_W-1:0] best_pos_reg,   best_pos_next;
    logic [LUM_W-1:0] best_lum_reg,   best_lum_next;
    logic [HUE_W-1:0] best_score_reg, best_score_next;
    logic             ovf_reg,        ovf_next;

    logic [HUE_W-1:0] diff_new;
    logic [HUE_W:0]   score_sum;
    logic [HUE_W-1:0] score;
    logic [CNT_W-1:0] cand;
    logic             row_full;

    // a last pixel waits for the output register; others always move
    assign s1_take   = s1_valid && (!s1_pix.last || out_free);
    assign res_valid = s1_take && s1_pix.last;

    // score of the middle pixel of the window: stored left diff plus new right diff
    assign diff_new  = circ_diff(prev_hue_reg, s1_pix.hue);
    assign score_sum = {1'b0, prev_diff_reg} + {1'b0, diff_new};
    assign score     = score_sum[HUE_W-1:0];
    assign cand      = count_reg - CNT_W'(1);
    assign row_full  = count_reg >= CNT_W'(MAX_ROW_WIDTH);

    always_comb
    begin
        prev_hue_next   = prev_hue_reg;
        prev_diff_next  = prev_diff_reg;
        count_next      = count_reg;
        best_pos_next   = best_pos_reg;
        best_lum_next   = best_lum_reg;
        best_score_next = best_score_reg;
        ovf_next        = ovf_reg;
        res             = '{position: '0, status: ROW_OK};

        if (s1_take)
        begin
            if (row_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                if (!mode)
                begin
                    // luminance: the pixel itself competes, first interior is default
                    if (!s1_pix.last && (count_reg != '0))
                    begin
                        if ((count_reg == CNT_W'(1)) || (s1_pix.luminance < best_lum_reg))
                        begin
                            best_lum_next = s1_pix.luminance;
                            best_pos_next = count_reg[POS_W-1:0];
                        end
                    end
                end
                else
                begin
                    // hue: this pixel completes the score of its left neighbor
                    if (count_reg >= CNT_W'(2))
                    begin
                        if ((count_reg == CNT_W'(2)) || (score < best_score_reg))
                        begin
                            best_score_next = score;
                            best_pos_next   = cand[POS_W-1:0];
                        end
                    end
                end
                prev_hue_next  = s1_pix.hue;
                prev_diff_next = diff_new;
                count_next     = count_reg + CNT_W'(1);
            end

            if (s1_pix.last)
            begin
                if (ovf_next)
                begin
                    res = '{position: '0, status: ROW_OVERFLOW};
                end
                else if (count_next < CNT_W'(3))
                begin
                    res = '{position: '0, status: ROW_SHORT};
                end
                else
                begin
                    res = '{position: best_pos_next, status: ROW_OK};
                end

                // row done: back to the cleared state
                prev_hue_next   = '0;
                prev_diff_next  = '0;
                count_next      = '0;
                best_pos_next   = '0;
                best_lum_next   = '1;
                best_score_next = '1;
                ovf_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_hue_reg   <= '0;
            prev_diff_reg  <= '0;
            count_reg      <= '0;
            best_pos_reg   <= '0;
            best_lum_reg   <= '1;
            best_score_reg <= '1;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            prev_hue_reg   <= prev_hue_next;
            prev_diff_reg  <= prev_diff_next;
            count_reg      <= count_next;
            best_pos_reg   <= best_pos_next;
            best_lum_reg   <= best_lum_next;
            best_score_reg <= best_score_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

// ===== hdl/rcns_out_stage.sv =====
// Result register: holds one row result until the downstream takes the beat.
// Depends on rcns_pkg.
module rcns_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  rcns_pkg::result_t res,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_ready,
    output rcns_pkg::result_t out_res
);
    import rcns_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule
